// File: design/vt4_pkg.sv
`default_nettype none

package vt4_pkg;

    // Vertex and matrix geometry.
    localparam int NUM_COMP    = 4;
    localparam int NUM_REGS    = 8;
    localparam int REG_W       = 64;
    localparam int Q_W         = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_SEL_W   = $clog2(NUM_REGS);

    // Arithmetic widths: a full product, a sum of two, a sum of four.
    localparam int PROD_W = 2 * Q_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Identity matrix, two Q16.16 entries per register, low half first.
    localparam logic [NUM_REGS-1:0][REG_W-1:0] REG_RESET = {
        64'h0001_0000_0000_0000,  // row 3, columns 2 and 3
        64'h0000_0000_0000_0000,  // row 3, columns 0 and 1
        64'h0000_0000_0001_0000,  // row 2, columns 2 and 3
        64'h0000_0000_0000_0000,  // row 2, columns 0 and 1
        64'h0000_0000_0000_0000,  // row 1, columns 2 and 3
        64'h0001_0000_0000_0000,  // row 1, columns 0 and 1
        64'h0000_0000_0000_0000,  // row 0, columns 2 and 3
        64'h0000_0000_0001_0000   // row 0, columns 0 and 1
    };

    // One vertex or one matrix column: four Q16.16 words.
    typedef logic [NUM_COMP-1:0][Q_W-1:0] quad_t;

    // Matrix seen column by column: [column][row].
    typedef logic [NUM_COMP-1:0][NUM_COMP-1:0][Q_W-1:0] matrix_t;

    // Stage loads that the top level hands to every lane.
    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// File: design/vertex_transform_4x4_core.sv
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------
// vertex   | vtx_valid / vtx_ready | vx, vy, vz, vw (signed Q16.16)
// result   | res_valid / res_ready | out_x, out_y, out_z, out_w (Q16.16, sat)
// config   | cfg_valid / cfg_ready | cfg_index (0..7), cfg_data (64 bits)
//
// One request enters per cycle while vtx_ready is high; its result passes
// through the 32x32 multipliers, the pairwise adders and the final add with
// saturation into the output register, which each take one stage.
// Reset clears every valid bit and restores the identity matrix.
// Each stage moves on whenever the stage after it is empty or moving, so a
// stalled result only blocks the input once all three stages hold requests.
// Configuration writes are always taken; cfg_ready is tied high.

module vertex_transform_4x4_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            vtx_valid,
    output logic                                 vtx_ready,
    input  wire logic signed [vt4_pkg::Q_W-1:0]  vx,
    input  wire logic signed [vt4_pkg::Q_W-1:0]  vy,
    input  wire logic signed [vt4_pkg::Q_W-1:0]  vz,
    input  wire logic signed [vt4_pkg::Q_W-1:0]  vw,

    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output logic signed [vt4_pkg::Q_W-1:0]       out_x,
    output logic signed [vt4_pkg::Q_W-1:0]       out_y,
    output logic signed [vt4_pkg::Q_W-1:0]       out_z,
    output logic signed [vt4_pkg::Q_W-1:0]       out_w,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [vt4_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [vt4_pkg::REG_W-1:0]       cfg_data
);
    import vt4_pkg::*;

    // The matrix, regrouped so that each lane sees one column.
    matrix_t    matrix;
    quad_t      vertex;
    quad_t      lane_result;
    lane_ctrl_t ctrl;

    // Valid bits of the product stage, the pair-sum stage and the output.
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic res_valid_reg, res_valid_next;

    // Each stage may load when it is empty or when its contents move on.
    logic s1_ready, s2_ready, res_load;

    // Merged output register, one word per lane.
    quad_t out_reg;

    assign cfg_ready = 1'b1;

    vt4_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .matrix    (matrix)
    );

    assign vertex = {vw, vz, vy, vx};

    assign res_load  = !res_valid_reg || res_ready;
    assign s2_ready  = !s2_valid_reg || res_load;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign vtx_ready = s1_ready;

    assign ctrl.s1_load = s1_ready;
    assign ctrl.s2_load = s2_ready;

    // Four lanes, one per output column, all fed the same vertex.
    for (genvar c = 0; c < NUM_COMP; c++)
    begin : g_lane
        vt4_lane u_lane (
            .clk    (clk),
            .ctrl   (ctrl),
            .vertex (vertex),
            .column (matrix[c]),
            .result (lane_result[c])
        );
    end

    always_comb
    begin
        s1_valid_next  = s1_ready ? vtx_valid    : s1_valid_reg;
        s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
        res_valid_next = res_load ? s2_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // The merge stage gathers the four lane results into one request.
    always_ff @(posedge clk)
    begin
        if (res_load && s2_valid_reg)
        begin
            out_reg <= lane_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];
    assign out_z     = out_reg[2];
    assign out_w     = out_reg[3];

    // The input is refused only when every stage is full and the output stalls.
    a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !vtx_ready |-> (s1_valid_reg && s2_valid_reg && res_valid_reg && !res_ready))
        else $error("input refused while the pipeline can still advance");

    // A request in the product stage moves on when the next stage can take it.
    a_s1_advance : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> s2_valid_reg)
        else $error("request lost between product and sum stages");

    // A new result only appears when the sum stage held a request.
    a_res_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s2_valid_reg))
        else $error("result raised without a request behind it");

endmodule

`default_nettype wire

// File: design/vt4_regs.sv
`default_nettype none

module vt4_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [vt4_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [vt4_pkg::REG_W-1:0]       cfg_data,
    output vt4_pkg::matrix_t                     matrix
);
    import vt4_pkg::*;

    logic [NUM_REGS-1:0][REG_W-1:0] regs_reg;
    logic [NUM_REGS-1:0][REG_W-1:0] regs_next;

    // Writes to an index past the last register are dropped.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid && (cfg_index < CFG_INDEX_W'(NUM_REGS)))
        begin
            regs_next[cfg_index[CFG_SEL_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= REG_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    // Entry [r][c] sits in register 2r + c/2, half c%2.
    for (genvar c = 0; c < NUM_COMP; c++)
    begin : g_col
        for (genvar r = 0; r < NUM_COMP; r++)
        begin : g_row
            assign matrix[c][r] = regs_reg[r * 2 + c / 2][(c % 2) * Q_W +: Q_W];
        end
    end

endmodule

`default_nettype wire

// File: design/vt4_lane.sv
`default_nettype none

module vt4_lane (
    input  wire logic                 clk,
    input  wire vt4_pkg::lane_ctrl_t  ctrl,
    input  wire vt4_pkg::quad_t       vertex,
    input  wire vt4_pkg::quad_t       column,
    output logic [vt4_pkg::Q_W-1:0]   result
);
    import vt4_pkg::*;

    localparam int SAT_W = SUM_W - FRAC_BITS - Q_W + 1;

    logic signed [PROD_W-1:0] prod_reg [NUM_COMP];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  sum;
    logic [SAT_W-1:0]         top_bits;
    logic                     fits;

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            for (int r = 0; r < NUM_COMP; r++)
            begin
                prod_reg[r] <= $signed(column[r]) * $signed(vertex[r]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_load)
        begin
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
    end

    // The arithmetic shift is a plain bit select of the exact sum, which
    // truncates toward minus infinity; the result fits when the bits above
    // the kept word all copy its sign.
    always_comb
    begin
        sum      = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        top_bits = sum[SUM_W-1 -: SAT_W];
        fits     = (&top_bits) || !(|top_bits);
        if (fits)
        begin
            result = sum[FRAC_BITS +: Q_W];
        end
        else if (sum[SUM_W-1])
        begin
            result = Q_MIN;
        end
        else
        begin
            result = Q_MAX;
        end
    end

endmodule

`default_nettype wire

// File: verif/tb_vertex_transform_4x4_core.sv
`timescale 1ns / 1ps

module tb_vertex_transform_4x4_core;

    import vt4_pkg::*;

    localparam int          RESET_CYCLES  = 12;
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ITEMS   = 250;
    // The pipeline is three stages deep, so a few extra cycles after the last
    // result are enough to catch anything the block should not have sent.
    localparam int          DRAIN_CYCLES  = 10;
    // The slowest correct run stays well under CYCLE_LIMIT even when every
    // request waits out the longest sender gap and the longest result stall.
    localparam int unsigned CYCLE_LIMIT   = 600000;

    // Matrix entries mostly stay within +/-4.0 and vertex components within
    // +/-256.0, so that a good share of the results do not saturate.
    localparam int unsigned MATRIX_SPAN = 32'h0004_0000;
    localparam int unsigned VERTEX_SPAN = 32'h0100_0000;

    localparam logic [Q_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [Q_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [Q_W-1:0] Q_LSB     = 32'h0000_0001;
    localparam logic [Q_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(Q_MAX);
    localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'($signed(Q_MIN));

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   vtx_valid = 1'b0;
    logic                   vtx_ready;
    logic signed [Q_W-1:0]  vx = '0;
    logic signed [Q_W-1:0]  vy = '0;
    logic signed [Q_W-1:0]  vz = '0;
    logic signed [Q_W-1:0]  vw = '0;

    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic signed [Q_W-1:0]  out_x;
    logic signed [Q_W-1:0]  out_y;
    logic signed [Q_W-1:0]  out_z;
    logic signed [Q_W-1:0]  out_w;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]       cfg_data  = '0;

    // Our own copy of the matrix registers, updated as each write is taken.
    logic [REG_W-1:0] matrix_regs [NUM_REGS];

    quad_t pending_vertices [$];
    quad_t predicted_results [$];

    int unsigned vtx_idle_pct = 0;
    int unsigned res_idle_pct = 0;
    int unsigned vtx_gap      = 0;
    int unsigned res_stall    = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;

    string result_names [NUM_COMP] = '{"out_x", "out_y", "out_z", "out_w"};

    vertex_transform_4x4_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vx        (vx),
        .vy        (vy),
        .vz        (vz),
        .vw        (vw),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Row vector times matrix: column c sums M[r][c] * v[r] over all rows.
    // The sum is kept at full width (66 bits covers four Q32.32 products),
    // shifted arithmetically, which truncates toward minus infinity, and
    // only then clamped to the 32-bit signed range.
    function automatic quad_t transform_vertex(quad_t vert);
        quad_t                     res;
        logic signed [Q_W-1:0]     coef;
        logic signed [Q_W-1:0]     comp;
        logic signed [PROD_W-1:0]  prod;
        logic signed [SUM_W-1:0]   acc;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            acc = '0;
            for (int r = 0; r < NUM_COMP; r++)
            begin
                coef = matrix_regs[2 * r + c / 2][(c % 2) * Q_W +: Q_W];
                comp = vert[r];
                prod = coef * comp;
                acc  = acc + prod;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > SUM_HI)
                res[c] = Q_MAX;
            else if (acc < SUM_LO)
                res[c] = Q_MIN;
            else
                res[c] = acc[Q_W-1:0];
        end
        return res;
    endfunction

    // Length of an idle stretch: none except in pct percent of the calls, and
    // then mostly a short one and once in ten a long one.
    function automatic int unsigned idle_length(int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // A Q16.16 word: mostly small values, some full-range random patterns,
    // and some corner values.
    function automatic logic [Q_W-1:0] random_q(int unsigned span);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(0, 2 * span) - span;
        if (pick < 85)
            return $urandom;
        case ($urandom_range(0, 6))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return Q_NEG_LSB;
            3:       return Q_LSB;
            4:       return Q_ONE;
            5:       return Q_NEG_ONE;
            default: return '0;
        endcase
    endfunction

    task automatic queue_vertex(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b,
                                input logic [Q_W-1:0] c, input logic [Q_W-1:0] d);
        pending_vertices.push_back({d, c, b, a});
    endtask

    // Called right after a rising edge. The valid stays high on return so that
    // back-to-back writes need only one assignment per edge; the caller drops
    // it after the last write.
    task automatic program_reg(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [REG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        // Writes to indexes past the last register are dropped by the block.
        if (idx < NUM_REGS)
            matrix_regs[idx[CFG_SEL_W-1:0]] = data;
    endtask

    task automatic load_uniform(input logic [Q_W-1:0] entry);
        @(posedge clk);
        for (int i = 0; i < NUM_REGS; i++)
            program_reg(CFG_INDEX_W'(i), {entry, entry});
        cfg_valid <= 1'b0;
    endtask

    // Idle means every queued request has been taken and every predicted
    // result has come back, so the pipeline is empty.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_vertices.size() != 0 || vtx_valid || predicted_results.size() != 0);
    endtask

    // Request driver. The prediction is made at the edge where the request is
    // taken, against the matrix as it stands then; the matrix only changes
    // while the block is idle.
    always @(posedge clk or negedge rst_n)
    begin
        quad_t next_vertex;
        if (!rst_n)
        begin
            vtx_valid <= 1'b0;
            vtx_gap   <= 0;
        end
        else
        begin
            if (vtx_valid && vtx_ready)
                predicted_results.push_back(transform_vertex({vw, vz, vy, vx}));
            if (!vtx_valid || vtx_ready)
            begin
                if (vtx_gap > 0)
                begin
                    vtx_gap   <= vtx_gap - 1;
                    vtx_valid <= 1'b0;
                end
                else if (pending_vertices.size() > 0)
                begin
                    next_vertex = pending_vertices.pop_front();
                    vx        <= next_vertex[0];
                    vy        <= next_vertex[1];
                    vz        <= next_vertex[2];
                    vw        <= next_vertex[3];
                    vtx_valid <= 1'b1;
                    vtx_gap   <= idle_length(vtx_idle_pct);
                end
                else
                begin
                    vtx_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        quad_t got;
        quad_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            res_stall <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got = {out_w, out_z, out_y, out_x};
                if (predicted_results.size() == 0)
                begin
                    $error("result %h arrived with no request outstanding", got);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    for (int c = 0; c < NUM_COMP; c++)
                    begin
                        if (got[c] !== want[c])
                        begin
                            $error("%s: expected %0d, got %0d", result_names[c],
                                   $signed(want[c]), $signed(got[c]));
                            error_count++;
                        end
                    end
                end
            end
            if (res_stall > 0)
            begin
                res_stall <= res_stall - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                res_stall <= idle_length(res_idle_pct);
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** vertex_transform_4x4_core: FAILED **");
        $finish;
    end

    initial
    begin
        logic [Q_W-1:0] lo_entry;
        logic [Q_W-1:0] hi_entry;
        int unsigned    extra_writes;

        matrix_regs = '{REG_RESET[0], REG_RESET[1], REG_RESET[2], REG_RESET[3],
                        REG_RESET[4], REG_RESET[5], REG_RESET[6], REG_RESET[7]};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Identity matrix out of reset: the vertex must pass through unchanged,
        // field extremes included.
        queue_vertex('0, '0, '0, '0);
        queue_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        queue_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        queue_vertex(Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB);
        queue_vertex(Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN);
        wait_idle();

        // Largest positive entries everywhere: saturation high and low, and a
        // mixed vertex whose huge products cancel down to a modest result.
        load_uniform(Q_MAX);
        queue_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        queue_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        queue_vertex(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        wait_idle();

        // Most negative entries: four products of -2^31 * -2^31 sum to 2^64,
        // which only a full-width sum gets right before saturating.
        load_uniform(Q_MIN);
        queue_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        queue_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        queue_vertex('0, '0, '0, '0);
        wait_idle();

        // Smallest entries: a sum of -4 LSBs must truncate to -1, not to 0,
        // and exactly one unit must appear when the fraction sum carries.
        load_uniform(Q_LSB);
        queue_vertex(Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB);
        queue_vertex(Q_LSB, Q_LSB, Q_LSB, Q_LSB);
        queue_vertex(32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000);
        queue_vertex(Q_NEG_LSB, Q_LSB, Q_NEG_LSB, Q_LSB);
        wait_idle();

        // Writes past the last register must leave the matrix alone.
        @(posedge clk);
        program_reg(CFG_INDEX_W'(NUM_REGS), '0);
        program_reg({CFG_INDEX_W{1'b1}}, '0);
        cfg_valid <= 1'b0;
        queue_vertex(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        wait_idle();

        // Entries 1.0 through 16.0 in row-major order, so that any mix-up of
        // rows, columns or register halves shows in the result.
        @(posedge clk);
        for (int r = 0; r < NUM_COMP; r++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                lo_entry = (4 * r + 2 * h + 1) << FRAC_BITS;
                hi_entry = (4 * r + 2 * h + 2) << FRAC_BITS;
                program_reg(CFG_INDEX_W'(2 * r + h), {hi_entry, lo_entry});
            end
        end
        cfg_valid <= 1'b0;
        queue_vertex(Q_ONE, '0, '0, '0);
        queue_vertex('0, '0, '0, Q_ONE);
        queue_vertex(Q_ONE, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
        wait_idle();

        // Random phases, each with a fresh matrix and its own idling. The first
        // runs with no idling on either side, the second with a sender that
        // never pauses against heavy back-pressure.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            @(posedge clk);
            for (int i = 0; i < NUM_REGS; i++)
                program_reg(CFG_INDEX_W'(i),
                            {random_q(MATRIX_SPAN), random_q(MATRIX_SPAN)});
            extra_writes = $urandom_range(0, 3);
            repeat (extra_writes)
                program_reg(CFG_INDEX_W'($urandom_range(0, (1 << CFG_INDEX_W) - 1)),
                            {$urandom, $urandom});
            cfg_valid <= 1'b0;

            vtx_idle_pct = (phase < 2) ? 0 : $urandom_range(5, 50);
            res_idle_pct = (phase == 0) ? 0 : (phase == 1) ? 60 : $urandom_range(5, 50);

            repeat (PHASE_ITEMS)
                queue_vertex(random_q(VERTEX_SPAN), random_q(VERTEX_SPAN),
                             random_q(VERTEX_SPAN), random_q(VERTEX_SPAN));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** vertex_transform_4x4_core: PASSED **");
        else
            $display("** vertex_transform_4x4_core: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
design/vt4_pkg.sv
design/vt4_regs.sv
design/vt4_lane.sv
design/vertex_transform_4x4_core.sv
verif/tb_vertex_transform_4x4_core.sv
